>>> src/rbem_pkg.sv
package rbem_pkg;

	localparam int FRAME_WIDTH  = 256;
	localparam int FRAME_HEIGHT = 256;

	localparam int COL_W = $clog2(FRAME_WIDTH);
	localparam int ROW_W = $clog2(FRAME_HEIGHT);

	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 2;
	localparam int DIST_W    = 10;

	localparam logic [CFG_W-1:0] THRESHOLD_RESET = 10'd60;
	localparam logic [7:0]       MARK_RED_RESET  = 8'd20;
	localparam logic [7:0]       MARK_GREEN_RESET = 8'd20;
	localparam logic [7:0]       MARK_BLUE_RESET = 8'd25;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EDGE_THRESHOLD = 2'd0,
		REG_MARK_RED       = 2'd1,
		REG_MARK_GREEN     = 2'd2,
		REG_MARK_BLUE      = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		pixel_t pix;
		logic   marked;
		logic   last;
		logic   fend;
	} result_t;

	typedef struct packed {
		logic interior;
		logic last_row;
		logic col_last;
	} pos_t;

endpackage

>>> src/rbem_cell.sv
module rbem_cell (
	input  logic             clk,
	input  logic             shift_en,
	input  rbem_pkg::pixel_t din,
	output rbem_pkg::pixel_t dout
);

	rbem_pkg::pixel_t pix_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			pix_q <= din;
		end
	end

	assign dout = pix_q;

endmodule

>>> src/rbem_line_chain.sv
module rbem_line_chain (
	input  logic             clk,
	input  logic             shift_en,
	input  rbem_pkg::pixel_t din,
	output rbem_pkg::pixel_t upper,
	output rbem_pkg::pixel_t right
);

	rbem_pkg::pixel_t tap [rbem_pkg::FRAME_WIDTH];

	for (genvar i = 0; i < rbem_pkg::FRAME_WIDTH; i++) begin : g_cell
		if (i == 0) begin : g_head
			rbem_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.din      (din),
				.dout     (tap[i])
			);
		end else begin : g_body
			rbem_cell u_cell (
				.clk      (clk),
				.shift_en (shift_en),
				.din      (tap[i-1]),
				.dout     (tap[i])
			);
		end
	end

	// oldest cell is the pixel above, the next one the pixel above-right
	assign upper = tap[rbem_pkg::FRAME_WIDTH-1];
	assign right = tap[rbem_pkg::FRAME_WIDTH-2];

endmodule

>>> src/rbem_edge_unit.sv
module rbem_edge_unit (
	input  rbem_pkg::pixel_t          upper,
	input  rbem_pkg::pixel_t          right,
	input  rbem_pkg::pixel_t          cur,
	input  rbem_pkg::pos_t            pos,
	input  logic [rbem_pkg::CFG_W-1:0] threshold,
	input  rbem_pkg::pixel_t          mark,
	output rbem_pkg::result_t         res_upper,
	output rbem_pkg::result_t         res_cur
);

	function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [rbem_pkg::DIST_W-1:0] pixel_dist(input rbem_pkg::pixel_t p,
			input rbem_pkg::pixel_t q);
		pixel_dist = {2'b00, absdiff(p.red, q.red)} + {2'b00, absdiff(p.green, q.green)}
			+ {2'b00, absdiff(p.blue, q.blue)};
	endfunction

	logic marked;

	assign marked = pos.interior &&
		((pixel_dist(upper, right) > threshold) || (pixel_dist(upper, cur) > threshold));

	always_comb begin
		res_upper.pix    = marked ? mark : upper;
		res_upper.marked = marked;
		res_upper.last   = !pos.last_row;
		res_upper.fend   = 1'b0;
		res_cur.pix      = cur;
		res_cur.marked   = 1'b0;
		res_cur.last     = 1'b1;
		res_cur.fend     = pos.col_last;
	end

endmodule

>>> src/rbem_out_queue.sv
module rbem_out_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_cnt,
	input  rbem_pkg::result_t push0,
	input  rbem_pkg::result_t push1,
	input  logic              pop,
	output rbem_pkg::result_t head,
	output logic              head_valid,
	output logic [1:0]        count
);

	rbem_pkg::result_t slot_q [2];
	rbem_pkg::result_t slot_nxt [2];
	logic [1:0] cnt_q;
	logic [1:0] cnt_nxt;

	always_comb begin
		slot_nxt = slot_q;
		cnt_nxt  = cnt_q;
		if (pop) begin
			slot_nxt[0] = slot_q[1];
			cnt_nxt     = cnt_q - 2'd1;
		end
		if (push_cnt != 2'd0) begin
			slot_nxt[cnt_nxt[0]] = push0;
		end
		if (push_cnt == 2'd2) begin
			slot_nxt[1] = push1;
		end
		cnt_nxt = cnt_nxt + push_cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_nxt;
		end
	end

	always_ff @(posedge clk) begin
		slot_q <= slot_nxt;
	end

	assign head       = slot_q[0];
	assign head_valid = (cnt_q != 2'd0);
	assign count      = cnt_q;

endmodule

>>> src/rgb_boundary_edge_marker.sv
// RGB boundary edge marker.
// Input channel (in_valid/in_ready): one RGB pixel per request in raster
// order; frame_start flags column 0 of row 0 and restarts the position.
// Output channel (out_valid/out_ready): finished pixels, one per request.
// Row r leaves while row r+1 comes in: pixel (x, r-1) is queued when
// pixel (x, r) is accepted. Row 0 yields nothing; each pixel of the
// last row yields two requests (the pixel above, then itself).
// Throughput: one pixel per cycle while results drain; in the last row
// the input slows, as the single-request output port sends two per pixel.
// The line store is a chain of FRAME_WIDTH pixel cells shifting once per
// accepted pixel. A two-entry result queue sits in front of the output, so
// input keeps flowing while a result waits.
// Reset: position goes to (0, 0), registers to 60 / 20,20,25, the queue
// empties; line contents are not cleared (row 0 refills them).
// Receiver stall: the queue fills and in_ready drops until room is there.
// Config writes (cfg_we) take effect at once; write only while idle.
module rgb_boundary_edge_marker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      in_red,
	input  logic [7:0]                      in_green,
	input  logic [7:0]                      in_blue,
	input  logic                            frame_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_red,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_blue,
	output logic                            edge_marked,
	output logic                            run_last,
	output logic                            frame_end,
	input  logic                            cfg_we,
	input  logic [rbem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rbem_pkg::CFG_W-1:0]      cfg_data
);

	localparam logic [rbem_pkg::COL_W-1:0] COL_LAST = rbem_pkg::COL_W'(rbem_pkg::FRAME_WIDTH - 1);
	localparam logic [rbem_pkg::ROW_W-1:0] ROW_LAST = rbem_pkg::ROW_W'(rbem_pkg::FRAME_HEIGHT - 1);

	logic [rbem_pkg::CFG_W-1:0] threshold_q;
	rbem_pkg::pixel_t           mark_q;
	logic [rbem_pkg::COL_W-1:0] col_q;
	logic [rbem_pkg::ROW_W-1:0] row_q;

	logic [rbem_pkg::COL_W-1:0] x;
	logic [rbem_pkg::ROW_W-1:0] r;
	logic                       accept;
	logic                       pop;
	rbem_pkg::pixel_t           cur;
	rbem_pkg::pixel_t           upper;
	rbem_pkg::pixel_t           right;
	rbem_pkg::pos_t             pos;
	rbem_pkg::result_t          res_upper;
	rbem_pkg::result_t          res_cur;
	rbem_pkg::result_t          head;
	logic                       head_valid;
	logic [1:0]                 count;
	logic [1:0]                 need;
	logic [1:0]                 push_cnt;
	logic [2:0]                 room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= rbem_pkg::THRESHOLD_RESET;
			mark_q.red   <= rbem_pkg::MARK_RED_RESET;
			mark_q.green <= rbem_pkg::MARK_GREEN_RESET;
			mark_q.blue  <= rbem_pkg::MARK_BLUE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rbem_pkg::REG_EDGE_THRESHOLD: threshold_q <= cfg_data;
				rbem_pkg::REG_MARK_RED:       mark_q.red <= cfg_data[7:0];
				rbem_pkg::REG_MARK_GREEN:     mark_q.green <= cfg_data[7:0];
				rbem_pkg::REG_MARK_BLUE:      mark_q.blue <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cur = '{red: in_red, green: in_green, blue: in_blue};
	assign x   = frame_start ? '0 : col_q;
	assign r   = frame_start ? '0 : row_q;

	// worst case from the stored position; frame_start only lowers it
	assign need = (row_q == '0) ? 2'd0 : ((row_q == ROW_LAST) ? 2'd2 : 2'd1);
	assign pop  = head_valid && out_ready;
	assign room = 3'd2 - {1'b0, count} + {2'b00, pop};
	assign in_ready = ({1'b0, need} <= room);
	assign accept = in_valid && in_ready;

	assign pos.interior = (r >= rbem_pkg::ROW_W'(2)) && (x != '0) && (x != COL_LAST);
	assign pos.last_row = (r == ROW_LAST);
	assign pos.col_last = (x == COL_LAST);

	assign push_cnt = !accept ? 2'd0 :
		(r == '0) ? 2'd0 : (pos.last_row ? 2'd2 : 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (x == COL_LAST) begin
				col_q <= '0;
				row_q <= (r == ROW_LAST) ? '0 : r + rbem_pkg::ROW_W'(1);
			end else begin
				col_q <= x + rbem_pkg::COL_W'(1);
				row_q <= r;
			end
		end
	end

	rbem_line_chain u_line (
		.clk      (clk),
		.shift_en (accept),
		.din      (cur),
		.upper    (upper),
		.right    (right)
	);

	rbem_edge_unit u_edge (
		.upper     (upper),
		.right     (right),
		.cur       (cur),
		.pos       (pos),
		.threshold (threshold_q),
		.mark      (mark_q),
		.res_upper (res_upper),
		.res_cur   (res_cur)
	);

	rbem_out_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (push_cnt),
		.push0      (res_upper),
		.push1      (res_cur),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.count      (count)
	);

	assign out_valid   = head_valid;
	assign out_red     = head.pix.red;
	assign out_green   = head.pix.green;
	assign out_blue    = head.pix.blue;
	assign edge_marked = head.marked;
	assign run_last    = head.last;
	assign frame_end   = head.fend;

endmodule

>>> src/rbem_checker.sv
module rbem_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic       edge_marked,
	input logic       run_last,
	input logic       frame_end
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_red) &&
		$stable(out_green) && $stable(out_blue) && $stable(edge_marked))
		else $error("stalled output request changed");

	a_fend_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> run_last && !edge_marked)
		else $error("frame end on a non-final or marked pixel");

	a_pair_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !run_last |=> out_valid)
		else $error("second result of a last-row pixel missing");

endmodule

bind rgb_boundary_edge_marker rbem_checker u_rbem_checker (.*);
